// ===== design/fhbp_pkg.sv =====
`timescale 1ns / 1ps

package fhbp_pkg;

   localparam int unsigned SIG_LEN = 8;
   localparam int unsigned WORDS_PART_ONE = 6;
   localparam int unsigned WORDS_TOTAL = 14;

   // Result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_SIG   = 2'd1;
   localparam logic [1:0] STATUS_BAD_VER   = 2'd2;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

   // Input item kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_EOS  = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_MIN_VERSION         = 2'd0;
   localparam logic [1:0] CSR_MAX_VERSION         = 2'd1;
   localparam logic [1:0] CSR_SECOND_PART_VERSION = 2'd2;

   localparam logic [31:0] MIN_VERSION_RESET         = 32'd2;
   localparam logic [31:0] MAX_VERSION_RESET         = 32'd9;
   localparam logic [31:0] SECOND_PART_VERSION_RESET = 32'd5;

   localparam logic [3:0] IDX_VERSION        = 4'd2;
   localparam logic [3:0] IDX_SECOND_VERSION = 4'd3;
   localparam logic [3:0] IDX_PART_ONE_LAST  = 4'(WORDS_PART_ONE - 1);
   localparam logic [3:0] IDX_LAST           = 4'(WORDS_TOTAL - 1);

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
   } item_type;

   typedef struct packed {
      logic [3:0]  field_index;
      logic [31:0] field_value;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] min_version;
      logic [31:0] max_version;
      logic [31:0] second_part_version;
   } cfg_type;

   function automatic logic [7:0] sig_byte(input logic [2:0] pos);
      logic [7:0] value;
      unique case (pos)
         3'd0: value = 8'h4E;
         3'd1: value = 8'h65;
         3'd2: value = 8'h6D;
         3'd3: value = 8'h6F;
         3'd4: value = 8'h20;
         3'd5: value = 8'h46;
         3'd6: value = 8'h69;
         3'd7: value = 8'h00;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

// ===== design/fhbp_in_stage.sv =====
`timescale 1ns / 1ps

module fhbp_in_stage
   import fhbp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  item_type req_item,
   input  logic     advance,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     accept;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== design/fhbp_core.sv =====
`timescale 1ns / 1ps

module fhbp_core
   import fhbp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     fire,
   input  item_type item,
   input  cfg_type  cfg,
   output logic     res_valid,
   output rsp_type  res
);

   logic [5:0]  pos_ff, pos_in;
   logic [31:0] word_ff, word_in;
   logic        mismatch_ff, mismatch_in;
   logic        second_ff, second_in;

   logic [5:0]  pos_off;
   logic [3:0]  widx;
   logic [1:0]  lane;
   logic [31:0] word_full;
   logic        in_sig;
   logic        mism;
   logic        rearm;

   assign in_sig    = pos_ff < 6'(SIG_LEN);
   assign pos_off   = pos_ff - 6'(SIG_LEN);
   assign widx      = in_sig ? 4'd0 : pos_off[5:2];
   assign lane      = pos_off[1:0];
   assign word_full = word_ff | ({24'd0, item.byte_value} << {lane, 3'b000});
   assign mism      = mismatch_ff || (item.byte_value != sig_byte(pos_ff[2:0]));

   always_comb begin
      pos_in      = pos_ff;
      word_in     = word_ff;
      mismatch_in = mismatch_ff;
      second_in   = second_ff;
      res_valid   = 1'b0;
      res         = '0;
      rearm       = 1'b0;
      if (fire) begin
         if (item.kind == KIND_EOS) begin
            res_valid = 1'b1;
            res       = '{field_index: widx, field_value: 32'd0,
                          status: STATUS_TRUNCATED, last: 1'b1};
            rearm     = 1'b1;
         end else if (in_sig) begin
            pos_in      = pos_ff + 6'd1;
            mismatch_in = mism;
            // signature is judged as a whole on its final byte
            if (pos_ff == 6'(SIG_LEN - 1) && mism) begin
               res_valid = 1'b1;
               res       = '{field_index: 4'd0, field_value: 32'd0,
                             status: STATUS_BAD_SIG, last: 1'b1};
               rearm     = 1'b1;
            end
         end else begin
            pos_in  = pos_ff + 6'd1;
            word_in = word_full;
            if (lane == 2'd3) begin
               word_in   = 32'd0;
               res_valid = 1'b1;
               res       = '{field_index: widx, field_value: word_full,
                             status: STATUS_OK, last: 1'b0};
               priority if (widx == IDX_VERSION) begin
                  if (word_full < cfg.min_version || word_full > cfg.max_version) begin
                     res.status = STATUS_BAD_VER;
                     res.last   = 1'b1;
                  end else begin
                     second_in = word_full >= cfg.second_part_version;
                  end
               end else if (widx == IDX_SECOND_VERSION) begin
                  if (word_full != 32'd0) begin
                     res.status = STATUS_BAD_VER;
                     res.last   = 1'b1;
                  end
               end else if (widx == IDX_PART_ONE_LAST && !second_ff) begin
                  res.last = 1'b1;
               end else if (widx >= IDX_LAST) begin
                  res.last = 1'b1;
               end else begin
                  res.last = 1'b0;
               end
               rearm = res.last;
            end
         end
      end
      if (rearm) begin
         pos_in      = 6'd0;
         word_in     = 32'd0;
         mismatch_in = 1'b0;
         second_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= 6'd0;
         word_ff     <= 32'd0;
         mismatch_ff <= 1'b0;
         second_ff   <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         word_ff     <= word_in;
         mismatch_ff <= mismatch_in;
         second_ff   <= second_in;
      end
   end

endmodule

// ===== design/fhbp_out_stage.sv =====
`timescale 1ns / 1ps

module fhbp_out_stage
   import fhbp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    res_valid,
   input  rsp_type res,
   output logic    advance,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   logic    valid_ff, valid_in;
   rsp_type rsp_ff;

   // take a new result whenever the held one is gone or leaving
   assign advance = !valid_ff || !rsp_stall;

   always_comb begin
      if (advance) begin
         valid_in = res_valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== design/file_header_byte_parser.sv =====
`timescale 1ns / 1ps
// A byte is accepted into the input register, and any result that it yields
// is written to the result register.
// Throughput: one byte per cycle unless the output stalls; the parse state
// updates in one step per byte. Reset clears the parse state and both stage
// valids, and loads the version registers with 2, 9 and 5.

module file_header_byte_parser
   import fhbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_field_index,
   output logic [31:0] rsp_field_value,
   output logic [1:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   cfg_type  cfg_ff;
   item_type req_item;
   item_type item;
   logic     item_valid;
   logic     advance;
   logic     res_valid;
   rsp_type  res;
   rsp_type  rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_version         <= MIN_VERSION_RESET;
         cfg_ff.max_version         <= MAX_VERSION_RESET;
         cfg_ff.second_part_version <= SECOND_PART_VERSION_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MIN_VERSION:         cfg_ff.min_version         <= csr_data;
            CSR_MAX_VERSION:         cfg_ff.max_version         <= csr_data;
            CSR_SECOND_PART_VERSION: cfg_ff.second_part_version <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_item = '{kind: req_kind, byte_value: req_byte_value};

   fhbp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   fhbp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (item_valid && advance),
      .item      (item),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   fhbp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_field_index = rsp.field_index;
   assign rsp_field_value = rsp.field_value;
   assign rsp_status      = rsp.status;
   assign rsp_last        = rsp.last;

   // any error status ends the header
   a_error_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_last)
      else $error("error result without last");

   a_trunc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_TRUNCATED || rsp_status == STATUS_BAD_SIG)
      |-> rsp_field_value == 32'd0)
      else $error("truncation or signature result carries a value");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_field_index <= IDX_LAST)
      else $error("field index out of range");

   // a stall on the request side only arises from a held, stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without backpressure");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import fhbp_pkg::*;

   localparam logic [7:0] MAGIC [8] = '{8'h4E, 8'h65, 8'h6D, 8'h6F,
                                         8'h20, 8'h46, 8'h69, 8'h00};
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned ITEM_TARGET = 450;

   typedef enum logic [1:0] {OP_BYTE, OP_CSR, OP_DRAIN} op_kind_type;

   typedef struct {
      op_kind_type what;
      logic        kind;
      logic [7:0]  data8;
      logic [1:0]  reg_idx;
      logic [31:0] reg_val;
   } feed_op_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = KIND_BYTE;
   logic [7:0]  req_byte_value = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_field_index;
   logic [31:0] rsp_field_value;
   logic [1:0]  rsp_status;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_MIN_VERSION;
   logic [31:0] csr_data = 32'd0;

   file_header_byte_parser uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_byte_value  (req_byte_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_field_index (rsp_field_index),
      .rsp_field_value (rsp_field_value),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus feed and the generator's view of the version registers
   feed_op_type byte_feed [$];
   int unsigned n_items = 0;
   logic [31:0] gen_min = MIN_VERSION_RESET;
   logic [31:0] gen_max = MAX_VERSION_RESET;
   logic [31:0] gen_part2 = SECOND_PART_VERSION_RESET;

   // parser shadow state
   int unsigned hdr_pos = 0;
   logic [31:0] word_acc = '0;
   logic        sig_bad = 1'b0;
   logic        want_part_two = 1'b0;
   logic [31:0] cfg_min = MIN_VERSION_RESET;
   logic [31:0] cfg_max = MAX_VERSION_RESET;
   logic [31:0] cfg_part2 = SECOND_PART_VERSION_RESET;
   rsp_type     pending_fields [$];

   int unsigned mismatches = 0;
   int unsigned status_seen [4] = '{0, 0, 0, 0};
   int unsigned n_eos = 0;
   int unsigned n_writes = 0;
   int unsigned n_sent = 0;
   int unsigned quiet_cycles = 0;
   int unsigned idle_cycles = 0;
   logic        calm = 1'b0;

   task automatic post_field(input logic [3:0] idx, input logic [31:0] val,
                             input logic [1:0] st, input logic lst);
      rsp_type r;
      r.field_index = idx;
      r.field_value = val;
      r.status = st;
      r.last = lst;
      pending_fields.push_back(r);
      if (lst) begin
         hdr_pos = 0;
         word_acc = '0;
         sig_bad = 1'b0;
         want_part_two = 1'b0;
      end
   endtask

   task automatic parse_byte(input logic kind, input logic [7:0] b);
      logic [3:0]  widx;
      logic [31:0] w;
      int unsigned lane;
      widx = (hdr_pos < SIG_LEN) ? 4'd0 : 4'((hdr_pos - SIG_LEN) >> 2);
      if (kind == KIND_EOS) begin
         post_field(widx, '0, STATUS_TRUNCATED, 1'b1);
      end else if (hdr_pos < SIG_LEN) begin
         if (b != MAGIC[hdr_pos]) sig_bad = 1'b1;
         hdr_pos++;
         if (hdr_pos == SIG_LEN && sig_bad) post_field('0, '0, STATUS_BAD_SIG, 1'b1);
      end else begin
         lane = (hdr_pos - SIG_LEN) & 3;
         word_acc |= 32'(b) << (8 * lane);
         hdr_pos++;
         if (lane == 3) begin
            w = word_acc;
            word_acc = '0;
            if (widx == IDX_VERSION) begin
               if (w < cfg_min || w > cfg_max) begin
                  post_field(widx, w, STATUS_BAD_VER, 1'b1);
               end else begin
                  want_part_two = (w >= cfg_part2);
                  post_field(widx, w, STATUS_OK, 1'b0);
               end
            end else if (widx == IDX_SECOND_VERSION) begin
               post_field(widx, w, (w != 0) ? STATUS_BAD_VER : STATUS_OK, w != 0);
            end else begin
               post_field(widx, w, STATUS_OK,
                          (widx == IDX_PART_ONE_LAST && !want_part_two) ||
                          widx >= IDX_LAST);
            end
         end
      end
   endtask

   // stimulus builders
   task automatic push_byte(input logic [7:0] b);
      byte_feed.push_back('{OP_BYTE, KIND_BYTE, b, CSR_MIN_VERSION, '0});
      n_items++;
   endtask

   task automatic push_eos();
      // the data lane is don't-care here, so keep it busy with noise
      byte_feed.push_back('{OP_BYTE, KIND_EOS, 8'($urandom), CSR_MIN_VERSION, '0});
      n_items++;
   endtask

   task automatic push_csr(input logic [1:0] idx, input logic [31:0] val);
      byte_feed.push_back('{OP_CSR, KIND_BYTE, 8'h00, idx, val});
      case (idx)
         CSR_MIN_VERSION: gen_min = val;
         CSR_MAX_VERSION: gen_max = val;
         default:         gen_part2 = val;
      endcase
   endtask

   task automatic push_drain();
      byte_feed.push_back('{OP_DRAIN, KIND_BYTE, 8'h00, CSR_MIN_VERSION, '0});
   endtask

   // one header: signature, words, optional corruption and early end of stream
   task automatic push_header(input logic [31:0] ver, input logic [31:0] second,
                              input int bad_sig_at, input int cut_at);
      logic [7:0]  hdr [$];
      logic [31:0] w;
      int          len;
      for (int i = 0; i < SIG_LEN; i++) hdr.push_back(MAGIC[i]);
      if (bad_sig_at >= 0) hdr[bad_sig_at] ^= 8'($urandom_range(255, 1));
      for (int k = 0; k < WORDS_TOTAL; k++) begin
         w = (k == IDX_VERSION) ? ver : (k == IDX_SECOND_VERSION) ? second : $urandom;
         for (int j = 0; j < 4; j++) hdr.push_back(w[8*j +: 8]);
      end
      if (bad_sig_at >= 0) len = SIG_LEN;
      else if (ver < gen_min || ver > gen_max) len = SIG_LEN + 12;
      else if (second != 0) len = SIG_LEN + 16;
      else if (ver >= gen_part2) len = SIG_LEN + 4 * WORDS_TOTAL;
      else len = SIG_LEN + 4 * WORDS_PART_ONE;
      if (cut_at >= 0 && cut_at < len) len = cut_at;
      for (int i = 0; i < len; i++) push_byte(hdr[i]);
      if (cut_at >= 0) push_eos();
   endtask

   task automatic push_random_header();
      logic [31:0] ver;
      logic [31:0] second;
      int          r;
      int          bad_at;
      int          cut;
      r = $urandom_range(9);
      case (r)
         0, 1, 2, 3, 4: ver = (gen_min <= gen_max) ? $urandom_range(gen_max, gen_min)
                                                   : $urandom;
         5: ver = gen_min;
         6: ver = gen_max;
         7: ver = gen_part2;
         8: ver = gen_min - 1;
         default: ver = $urandom;
      endcase
      second = ($urandom_range(99) < 12) ? $urandom_range(32'hFFFF_FFFF, 1) : '0;
      bad_at = ($urandom_range(99) < 12) ? $urandom_range(SIG_LEN - 1) : -1;
      cut = ($urandom_range(99) < 15) ? $urandom_range(SIG_LEN + 4 * WORDS_TOTAL - 1) : -1;
      push_header(ver, second, bad_at, cut);
   endtask

   task automatic push_noise();
      int n;
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 20) push_eos();
         else push_byte(8'($urandom));
      end
   endtask

   // driver
   always @(posedge clock) begin : drive
      logic req_done;
      logic csr_done;
      logic csr_next;
      logic send;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_done = req_valid && !req_stall;
         csr_done = csr_valid && csr_ready;
         csr_next = csr_valid && !csr_done;
         send = 1'b0;
         if (req_done) begin
            quiet_cycles = 0;
            n_sent++;
         end else if (quiet_cycles < 1000) begin
            quiet_cycles++;
         end
         calm <= (n_sent >= 150 && n_sent < 260);
         if ((!req_valid || req_done) && !(csr_valid && !csr_done) &&
             byte_feed.size() > 0) begin
            case (byte_feed[0].what)
               OP_BYTE: begin
                  if (calm || $urandom_range(99) >= 22) begin
                     send = 1'b1;
                     req_kind <= byte_feed[0].kind;
                     req_byte_value <= byte_feed[0].data8;
                     void'(byte_feed.pop_front());
                  end
               end
               OP_CSR: begin
                  // wait out bytes still in flight that may produce nothing
                  if (!req_valid && quiet_cycles >= SETTLE_CYCLES &&
                      pending_fields.size() == 0) begin
                     csr_next = 1'b1;
                     csr_index <= byte_feed[0].reg_idx;
                     csr_data <= byte_feed[0].reg_val;
                     void'(byte_feed.pop_front());
                  end
               end
               default: begin
                  if (!req_valid && pending_fields.size() == 0)
                     void'(byte_feed.pop_front());
               end
            endcase
         end
         csr_valid <= csr_next;
         if (!req_valid || req_done) req_valid <= send;
      end
   end

   // monitor: check results, predict accepted bytes, track register writes
   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.field_index = rsp_field_index;
            got.field_value = rsp_field_value;
            got.status = rsp_status;
            got.last = rsp_last;
            status_seen[rsp_status]++;
            if (pending_fields.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result idx=%0d val=%h st=%0d last=%b",
                           $realtime, got.field_index, got.field_value, got.status,
                           got.last);
            end else begin
               want = pending_fields.pop_front();
               if (got.field_index !== want.field_index ||
                   got.field_value !== want.field_value ||
                   got.status !== want.status || got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: result mismatch: expected idx=%0d val=%h st=%0d ",
                               "last=%b, got idx=%0d val=%h st=%0d last=%b"},
                              $realtime, want.field_index, want.field_value,
                              want.status, want.last, got.field_index,
                              got.field_value, got.status, got.last);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_kind == KIND_EOS) n_eos++;
            parse_byte(req_kind, req_byte_value);
         end
         if (csr_valid && csr_ready) begin
            n_writes++;
            case (csr_index)
               CSR_MIN_VERSION: cfg_min = csr_data;
               CSR_MAX_VERSION: cfg_max = csr_data;
               default:         cfg_part2 = csr_data;
            endcase
         end
         rsp_stall <= !calm && ($urandom_range(99) < 22);
      end
   end

   // watchdog on lack of progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("** file_header_byte_parser: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int phase;
      // directed: end of stream before any byte, bad signature,
      // partial signature then end of stream, extremes of version
      push_eos();
      push_header(32'd5, '0, SIG_LEN - 1, -1);
      push_header(32'd5, '0, -1, 3);
      push_header(32'hFFFF_FFFF, '0, -1, -1);
      push_header(32'd2, '0, -1, -1);
      push_header(32'd9, 32'h8000_0001, -1, -1);
      push_header(32'd5, '0, -1, SIG_LEN + 5);
      push_drain();

      phase = 0;
      while (n_items < ITEM_TARGET) begin
         if (n_items >= 120 + 70 * phase) begin
            case (phase)
               0: begin
                  push_csr(CSR_MIN_VERSION, 32'd0);
                  push_csr(CSR_MAX_VERSION, 32'hFFFF_FFFF);
                  push_csr(CSR_SECOND_PART_VERSION, 32'd0);
               end
               1: begin
                  push_csr(CSR_SECOND_PART_VERSION, 32'hFFFF_FFFF);
                  push_csr(CSR_MIN_VERSION, 32'hFFFF_FFFF);
               end
               2: begin
                  // inverted range rejects every version
                  push_csr(CSR_MIN_VERSION, 32'd10);
                  push_csr(CSR_MAX_VERSION, 32'd3);
               end
               3: begin
                  push_csr(CSR_MIN_VERSION, $urandom_range(1000));
                  push_csr(CSR_MAX_VERSION, $urandom_range(32'hFFFF_FFFF, 1000));
                  push_csr(CSR_SECOND_PART_VERSION, $urandom);
               end
               default: begin
                  push_csr(CSR_MIN_VERSION, MIN_VERSION_RESET);
                  push_csr(CSR_MAX_VERSION, MAX_VERSION_RESET);
                  push_csr(CSR_SECOND_PART_VERSION, SECOND_PART_VERSION_RESET);
               end
            endcase
            phase++;
         end
         if ($urandom_range(99) < 85) push_random_header();
         else push_noise();
         if ($urandom_range(99) < 4) push_drain();
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (byte_feed.size() != 0 || req_valid || csr_valid || pending_fields.size() != 0);
      repeat (8) @(posedge clock);

      $display("covered %0d items (%0d end of stream) and %0d register writes",
               n_items, n_eos, n_writes);
      $display("results: %0d ok, %0d bad signature, %0d bad version, %0d truncated",
               status_seen[STATUS_OK], status_seen[STATUS_BAD_SIG],
               status_seen[STATUS_BAD_VER], status_seen[STATUS_TRUNCATED]);
      if (mismatches == 0 && pending_fields.size() == 0) begin
         $display("** file_header_byte_parser: PASSED **");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, pending_fields.size());
         $display("** file_header_byte_parser: FAILED **");
      end
      $finish;
   end

endmodule
